/* rtl/ocwd_pkg.sv */
// ---------------------------------------------------------------------------
// ocwd_pkg - shared types and constants for the omni chassis wheel drive
// Request and result structs, register indexes, kinematic and filter
// constants, and the small remainder table used by the divide-by-100 step.
// ---------------------------------------------------------------------------
package ocwd_pkg;

  localparam int WheelCount = 4;
  localparam int WheelIdxW  = $clog2(WheelCount);

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int CmpW     = 13;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFilterGain = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFullScale  = 1'b1;

  localparam logic [CfgDataW-1:0] GainReset  = 16'd6554;
  localparam logic [CfgDataW-1:0] ScaleReset = 16'd7200;

  // stick decode
  localparam logic [7:0] PadModeMotion = 8'h73;
  localparam logic [8:0] CenterLr      = 9'd128;
  localparam logic [8:0] CenterUd      = 9'd127;

  // shared multiplier operand widths
  localparam int MulAW = 32;
  localparam int MulBW = 22;
  localparam int MulPW = MulAW + MulBW;

  // wheel speed coefficients in hundredths: 2*sin60/r, 2*cos60/r, 2*R/r
  localparam logic signed [MulBW-1:0] CoefX = 22'sd1732;
  localparam logic signed [MulBW-1:0] CoefY = 22'sd1000;
  localparam logic signed [MulBW-1:0] CoefW = 22'sd2040;

  // floor(a/25) = (a * RecipK) >> RecipShift, exact for a < 2^20
  localparam logic signed [MulBW-1:0] RecipK = 22'sd1342178;
  localparam int RecipShift = 25;

  typedef struct packed {
    logic [7:0] pad_mode;
    logic [7:0] right_lr;
    logic [7:0] right_ud;
    logic [7:0] left_lr;
  } pad_req_t;

  typedef struct packed {
    logic [CmpW-1:0] front_left_cmp_a;
    logic [CmpW-1:0] front_left_cmp_b;
    logic [CmpW-1:0] front_right_cmp_a;
    logic [CmpW-1:0] front_right_cmp_b;
    logic [CmpW-1:0] rear_left_cmp_a;
    logic [CmpW-1:0] rear_left_cmp_b;
    logic [CmpW-1:0] rear_right_cmp_a;
    logic [CmpW-1:0] rear_right_cmp_b;
  } drive_cmp_t;

  typedef struct packed {
    logic [CfgDataW-1:0] filter_gain;
    logic [CfgDataW-1:0] pwm_full_scale;
  } ocwd_cfg_t;

  // floor((16384*c + 12) / 25) for a remainder c of the divide by 25
  function automatic logic [13:0] frac_tab(input logic [4:0] c);
    logic [13:0] v;
    case (c)
      5'd0:    v = 14'd0;
      5'd1:    v = 14'd655;
      5'd2:    v = 14'd1311;
      5'd3:    v = 14'd1966;
      5'd4:    v = 14'd2621;
      5'd5:    v = 14'd3277;
      5'd6:    v = 14'd3932;
      5'd7:    v = 14'd4588;
      5'd8:    v = 14'd5243;
      5'd9:    v = 14'd5898;
      5'd10:   v = 14'd6554;
      5'd11:   v = 14'd7209;
      5'd12:   v = 14'd7864;
      5'd13:   v = 14'd8520;
      5'd14:   v = 14'd9175;
      5'd15:   v = 14'd9830;
      5'd16:   v = 14'd10486;
      5'd17:   v = 14'd11141;
      5'd18:   v = 14'd11796;
      5'd19:   v = 14'd12452;
      5'd20:   v = 14'd13107;
      5'd21:   v = 14'd13763;
      5'd22:   v = 14'd14418;
      5'd23:   v = 14'd15073;
      5'd24:   v = 14'd15729;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/ocwd_mul.sv */
// ---------------------------------------------------------------------------
// ocwd_mul - shared signed multiplier
// One signed multiply per cycle with the product registered.
// ---------------------------------------------------------------------------
module ocwd_mul (
  input  logic                                   clk,
  input  logic signed [ocwd_pkg::MulAW-1:0]      a,
  input  logic signed [ocwd_pkg::MulBW-1:0]      b,
  output logic signed [ocwd_pkg::MulPW-1:0]      p
);
  import ocwd_pkg::*;

  always_ff @(posedge clk) begin
    p <= MulPW'(a) * MulPW'(b);
  end

endmodule

/* rtl/ocwd_core.sv */
// ---------------------------------------------------------------------------
// ocwd_core - kinematics and filter sequencer
// Walks the four wheels through the shared multiplier: stick scaling,
// divide by 100, low-pass update and bridge compare split.
// ---------------------------------------------------------------------------
module ocwd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ocwd_pkg::pad_req_t   item,
  input  ocwd_pkg::ocwd_cfg_t  cfg,
  output logic                 idle,
  output logic                 res_valid,
  input  logic                 res_take,
  output ocwd_pkg::drive_cmp_t res
);
  import ocwd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MX, ST_MY, ST_MO, ST_CAP,
    ST_WT, ST_WA, ST_WB, ST_WQ, ST_WD, ST_WF, ST_WM, ST_WO,
    ST_DONE
  } state_t;

  state_t state;

  logic signed [8:0]  vx, vy, om;
  logic signed [18:0] px, po;
  logic signed [17:0] py;
  logic [WheelIdxW-1:0] wheel;
  logic [19:0] t_abs;
  logic        t_neg;
  logic [14:0] quo;
  logic [4:0]  rem5;
  logic signed [29:0] target;
  logic signed [17:0] mc;
  logic signed [31:0] filter [WheelCount];
  logic [CmpW-1:0] cmp_a [WheelCount];
  logic [CmpW-1:0] cmp_b [WheelCount];

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;

  logic signed [20:0] px_e, py_e, po_e, t_sum;
  logic [19:0] t_abs_next;
  logic [14:0] quo_next;
  logic [19:0] rem_full;
  logic [28:0] q_mag;
  logic signed [29:0] target_next;
  logic signed [31:0] y_cur, d_val, y_upd, ysum;
  logic [MulPW-1:0] rnd;
  logic signed [17:0] fse, me, mc_next, cmp_a_w, cmp_b_w;

  ocwd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    // wheel speed in hundredths: front left +x-y, front right -x-y,
    // rear left +x+y, rear right -x+y, rotation always subtracts
    px_e  = {{2{px[18]}}, px};
    py_e  = {{3{py[17]}}, py};
    po_e  = {{2{po[18]}}, po};
    t_sum = (wheel[0] ? -px_e : px_e) + (wheel[1] ? py_e : -py_e) - po_e;
    t_abs_next = t_sum[20] ? 20'(-t_sum) : t_sum[19:0];

    quo_next = prod[RecipShift+14:RecipShift];
    rem_full = t_abs - (20'({quo_next, 4'b0}) + 20'({quo_next, 3'b0}) + 20'(quo_next));

    q_mag       = {quo, 14'b0} + 29'(frac_tab(rem5));
    target_next = t_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    y_cur = filter[wheel];
    d_val = {{2{target[29]}}, target} - y_cur;

    // round half away from zero on the >>16
    rnd   = prod + (prod[MulPW-1] ? MulPW'(32767) : MulPW'(32768));
    y_upd = y_cur + $signed(rnd[47:16]);

    // truncate toward zero, then clamp to full scale
    ysum = y_cur + (y_cur[31] ? 32'sd65535 : 32'sd0);
    me   = {{2{ysum[31]}}, ysum[31:16]};
    fse  = $signed({2'b0, cfg.pwm_full_scale});
    if (me > fse) begin
      mc_next = fse;
    end else if (me < -fse) begin
      mc_next = -fse;
    end else begin
      mc_next = me;
    end

    if (mc > 18'sd0) begin
      cmp_a_w = fse;
      cmp_b_w = fse - mc;
    end else begin
      cmp_a_w = fse + mc;
      cmp_b_w = fse;
    end

    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MX: begin
        mul_a = {{23{vx[8]}}, vx};
        mul_b = CoefX;
      end
      ST_MY: begin
        mul_a = {{23{vy[8]}}, vy};
        mul_b = CoefY;
      end
      ST_MO: begin
        mul_a = {{23{om[8]}}, om};
        mul_b = CoefW;
      end
      ST_WA: begin
        mul_a = $signed({12'b0, t_abs});
        mul_b = RecipK;
      end
      ST_WD: begin
        mul_a = d_val;
        mul_b = $signed({6'b0, cfg.filter_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wheel <= '0;
      for (int i = 0; i < WheelCount; i++) begin
        filter[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (item.pad_mode == PadModeMotion) begin
              vx <= $signed({1'b0, item.right_lr} - CenterLr);
              vy <= $signed({1'b0, item.right_ud} - CenterUd);
              om <= $signed({1'b0, item.left_lr} - CenterLr);
            end else begin
              vx <= '0;
              vy <= '0;
              om <= '0;
            end
            state <= ST_MX;
          end
        end
        ST_MX: state <= ST_MY;
        ST_MY: begin
          px    <= prod[18:0];
          state <= ST_MO;
        end
        ST_MO: begin
          py    <= prod[17:0];
          state <= ST_CAP;
        end
        ST_CAP: begin
          po    <= prod[18:0];
          wheel <= '0;
          state <= ST_WT;
        end
        ST_WT: begin
          t_abs <= t_abs_next;
          t_neg <= t_sum[20];
          state <= ST_WA;
        end
        ST_WA: state <= ST_WB;
        ST_WB: begin
          quo   <= quo_next;
          rem5  <= rem_full[4:0];
          state <= ST_WQ;
        end
        ST_WQ: begin
          target <= target_next;
          state  <= ST_WD;
        end
        ST_WD: state <= ST_WF;
        ST_WF: begin
          filter[wheel] <= y_upd;
          state         <= ST_WM;
        end
        ST_WM: begin
          mc    <= mc_next;
          state <= ST_WO;
        end
        ST_WO: begin
          cmp_a[wheel] <= cmp_a_w[CmpW-1:0];
          cmp_b[wheel] <= cmp_b_w[CmpW-1:0];
          if (wheel == WheelIdxW'(WheelCount - 1)) begin
            state <= ST_DONE;
          end else begin
            wheel <= wheel + 1'b1;
            state <= ST_WT;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res.front_left_cmp_a  = cmp_a[0];
    res.front_left_cmp_b  = cmp_b[0];
    res.front_right_cmp_a = cmp_a[1];
    res.front_right_cmp_b = cmp_b[1];
    res.rear_left_cmp_a   = cmp_a[2];
    res.rear_left_cmp_b   = cmp_b[2];
    res.rear_right_cmp_a  = cmp_a[3];
    res.rear_right_cmp_b  = cmp_b[3];
  end

endmodule

/* rtl/omni_chassis_wheel_drive_top.sv */
// ---------------------------------------------------------------------------
// omni_chassis_wheel_drive_top - gamepad sample to four-wheel bridge compares
// One gamepad request in gives one set of eight H-bridge compare values out.
//
// in channel: in_valid/in_ready carry one pad_req_t request per control tick.
// out channel: out_valid/out_ready carry one drive_cmp_t result per request.
// cfg port: cfg_we writes cfg_wdata to register cfg_index at once
//   (0 filter gain, 1 pwm full scale); write only while the block is idle.
// Sequence: the setup states MX, MY, MO and CAP use the shared multiplier,
//   then the states WT to WO run once per wheel, all through one multiplier;
//   then ST_DONE hands the result over and the core returns to idle, so a
//   new request is taken only once the last one is through.
// The request is taken while a previous result still sits in the output
//   register; when the receiver stalls, the next result waits in the core
//   and no further request is taken until it moves to the output register.
// Reset: synchronous, clears the four filters to zero, restores the
//   register defaults and empties the output register.
// ---------------------------------------------------------------------------
module omni_chassis_wheel_drive_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ocwd_pkg::pad_req_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ocwd_pkg::drive_cmp_t              out_data,
  input  logic                              cfg_we,
  input  logic [ocwd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ocwd_pkg::CfgDataW-1:0]     cfg_wdata
);
  import ocwd_pkg::*;

  ocwd_cfg_t  cfg;
  logic       core_idle;
  logic       res_valid;
  logic       res_take;
  drive_cmp_t res;

  assign in_ready = core_idle;
  assign res_take = res_valid && (!out_valid || out_ready);

  ocwd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .item      (in_data),
    .cfg       (cfg),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_gain    <= GainReset;
      cfg.pwm_full_scale <= ScaleReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgFilterGain: cfg.filter_gain    <= cfg_wdata;
        CfgFullScale:  cfg.pwm_full_scale <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

/* sim/omni_chassis_wheel_drive_top_tb.sv */
// ---------------------------------------------------------------------------
// omni_chassis_wheel_drive_top_tb - self-checking bench for the wheel drive
// Sends gamepad requests, predicts the eight bridge compare values of each
// from a behavioral model of the kinematics and low-pass filters, and checks
// every result in order under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module omni_chassis_wheel_drive_top_tb;
  import ocwd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleWait  = 50;
  localparam int PhaseCount  = 8;
  localparam int PhaseLength = 200;
  localparam int LongHold    = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  pad_req_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  drive_cmp_t out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CfgFilterGain;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // behavioral copy of the block state
  longint drive_gain  = GainReset;
  longint drive_scale = ScaleReset;
  int     wheel_speed_q16[WheelCount] = '{default: 0};

  drive_cmp_t expected_drive[$];
  int err_count     = 0;
  int pad_count     = 0;
  int checked_count = 0;
  int setting_count = 0;
  int idle_pct      = 20;
  int hold_req      = 0;
  int cycle_count   = 0;

  string cmp_names[8] = '{"front_left_cmp_a", "front_left_cmp_b", "front_right_cmp_a",
                          "front_right_cmp_b", "rear_left_cmp_a", "rear_left_cmp_b",
                          "rear_right_cmp_a", "rear_right_cmp_b"};

  omni_chassis_wheel_drive_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // nearest integer, ties away from zero
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic drive_cmp_t predict_bridge(pad_req_t req);
    longint vx, vy, om, demand, target, y, m, ca, cb;
    logic [CmpW-1:0] a_cmp[WheelCount];
    logic [CmpW-1:0] b_cmp[WheelCount];
    vx = 0;
    vy = 0;
    om = 0;
    if (req.pad_mode == PadModeMotion) begin
      vx = longint'(req.right_lr) - longint'(CenterLr);
      vy = longint'(req.right_ud) - longint'(CenterUd);
      om = longint'(req.left_lr) - longint'(CenterLr);
    end
    for (int w = 0; w < WheelCount; w++) begin
      // speed in hundredths: x term flips on odd wheels, y term on the front pair
      demand = ((w % 2 == 0) ? 1732 : -1732) * vx + ((w < 2) ? -1000 : 1000) * vy
               - 2040 * om;
      target = round_div(demand * 65536, 100);
      y = wheel_speed_q16[w];
      y += round_div((target - y) * drive_gain, 65536);
      wheel_speed_q16[w] = int'(y);
      m = y / 65536;
      if (m > drive_scale) m = drive_scale;
      if (m < -drive_scale) m = -drive_scale;
      if (m > 0) begin
        ca = drive_scale;
        cb = drive_scale - m;
      end else begin
        ca = drive_scale + m;
        cb = drive_scale;
      end
      a_cmp[w] = ca[CmpW-1:0];
      b_cmp[w] = cb[CmpW-1:0];
    end
    return {a_cmp[0], b_cmp[0], a_cmp[1], b_cmp[1], a_cmp[2], b_cmp[2], a_cmp[3], b_cmp[3]};
  endfunction

  // result check first, then the request taken at the same edge
  always @(posedge clk) begin
    drive_cmp_t want;
    logic [CmpW-1:0] got_f, want_f;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          $error("bridge result with no request outstanding");
          err_count++;
        end else begin
          want = expected_drive.pop_front();
          checked_count++;
          for (int f = 0; f < 8; f++) begin
            got_f  = out_data[(7 - f) * CmpW +: CmpW];
            want_f = want[(7 - f) * CmpW +: CmpW];
            if (got_f !== want_f) begin
              $error("%s: expected %0d, got %0d", cmp_names[f], want_f, got_f);
              err_count++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_drive.push_back(predict_bridge(in_data));
        pad_count++;
      end
    end
  end

  // sink side: random stall bursts, plus a long hold-off on demand
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("omni_chassis_wheel_drive_top_tb: done, errors");
    $finish;
  end

  // returns right after the edge that took the request, valid left high
  task automatic send_pad(input pad_req_t req);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_sample(input logic [7:0] mode, input logic [7:0] rlr,
                             input logic [7:0] rud, input logic [7:0] llr);
    pad_req_t req;
    req.pad_mode = mode;
    req.right_lr = rlr;
    req.right_ud = rud;
    req.left_lr  = llr;
    send_pad(req);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  // block must be idle when this is called
  task automatic load_settings(input logic [CfgDataW-1:0] gain,
                               input logic [CfgDataW-1:0] scale);
    cfg_we    <= 1'b1;
    cfg_index <= CfgFilterGain;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_index <= CfgFullScale;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_we <= 1'b0;
    drive_gain  = gain;
    drive_scale = scale;
    setting_count++;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_stick();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'($urandom_range(126, 129));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_idle_mode();
    logic [7:0] m;
    m = 8'($urandom_range(0, 255));
    if (m == PadModeMotion) m = m ^ 8'h01;
    return m;
  endfunction

  task automatic test_stick_extremes();
    send_sample(PadModeMotion, 8'h80, 8'h7f, 8'h80);
    send_sample(PadModeMotion, 8'hff, 8'h7f, 8'h80);
    send_sample(PadModeMotion, 8'h00, 8'h7f, 8'h80);
    send_sample(PadModeMotion, 8'h80, 8'hff, 8'h80);
    send_sample(PadModeMotion, 8'h80, 8'h00, 8'h80);
    send_sample(PadModeMotion, 8'h80, 8'h7f, 8'hff);
    send_sample(PadModeMotion, 8'h80, 8'h7f, 8'h00);
    send_sample(PadModeMotion, 8'hff, 8'hff, 8'hff);
    send_sample(PadModeMotion, 8'h00, 8'h00, 8'h00);
  endtask

  // any other mode byte means stop, filters decay
  task automatic test_mode_gate();
    send_sample(8'h72, 8'hff, 8'hff, 8'hff);
    send_sample(8'h00, 8'h00, 8'h00, 8'h00);
    send_sample(8'hff, 8'hff, 8'h00, 8'hff);
    send_sample(8'h74, 8'h00, 8'hff, 8'h00);
  endtask

  task automatic test_full_scale_corners();
    settle_block();
    // zero full scale forces both compares to zero
    load_settings(16'hffff, 16'd0);
    send_sample(PadModeMotion, 8'hff, 8'h00, 8'h00);
    send_sample(PadModeMotion, 8'h00, 8'hff, 8'hff);
    settle_block();
    // full scale past the field width wraps the compares
    load_settings(16'hffff, 16'hffff);
    send_sample(PadModeMotion, 8'h00, 8'hff, 8'hff);
    send_sample(PadModeMotion, 8'hff, 8'h00, 8'h00);
    settle_block();
    load_settings(16'hffff, 16'd1);
    send_sample(PadModeMotion, 8'hff, 8'hff, 8'h00);
    send_sample(PadModeMotion, 8'h00, 8'h00, 8'hff);
  endtask

  task automatic test_gain_corners();
    settle_block();
    // zero gain freezes the filters
    load_settings(16'd0, ScaleReset);
    send_sample(PadModeMotion, 8'h00, 8'hff, 8'h80);
    send_sample(8'h00, 8'h12, 8'h34, 8'h56);
    settle_block();
    load_settings(16'hffff, 16'd8191);
    send_sample(PadModeMotion, 8'hff, 8'h00, 8'h00);
    send_sample(PadModeMotion, 8'h00, 8'hff, 8'hff);
  endtask

  // sink holds off while the source keeps offering, so the input backs up
  task automatic test_output_backpressure();
    int save_pct;
    settle_block();
    load_settings(GainReset, ScaleReset);
    save_pct = idle_pct;
    idle_pct = 0;
    hold_req = LongHold;
    for (int i = 0; i < 24; i++)
      send_sample(PadModeMotion, pick_stick(), pick_stick(), pick_stick());
    idle_pct = save_pct;
  endtask

  task automatic test_random_drive();
    int sent, run;
    logic [CfgDataW-1:0] gain, scale;
    pad_req_t req;
    for (int p = 0; p < PhaseCount; p++) begin
      settle_block();
      gain  = GainReset;
      scale = ScaleReset;
      if (p != 0 && p != PhaseCount - 1) begin
        case ($urandom_range(0, 4))
          0:       gain = 16'hffff;
          1:       gain = 16'($urandom_range(1, 300));
          default: gain = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
          0:       scale = 16'($urandom_range(8192, 65535));
          1:       scale = 16'($urandom_range(1, 40));
          2:       scale = (p == 3) ? 16'd0 : 16'd8191;
          default: scale = 16'($urandom_range(1, 8191));
        endcase
      end
      load_settings(gain, scale);
      // last phase, and phases 2 and 5, run with no gaps on either side
      case (p)
        PhaseCount - 1: idle_pct = 0;
        2, 5:           idle_pct = 0;
        default:        idle_pct = 10 + 15 * $urandom_range(0, 3);
      endcase
      sent = 0;
      while (sent < PhaseLength) begin
        // hold one stick position for a while so the filters settle on it
        if ($urandom_range(0, 9) < 8) req.pad_mode = PadModeMotion;
        else req.pad_mode = pick_idle_mode();
        req.right_lr = pick_stick();
        req.right_ud = pick_stick();
        req.left_lr  = pick_stick();
        run = $urandom_range(1, 40);
        for (int i = 0; i < run && sent < PhaseLength; i++) begin
          if ($urandom_range(0, 15) == 0) req.right_lr = 8'($urandom_range(0, 255));
          send_pad(req);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stick_extremes();
    test_mode_gate();
    test_full_scale_corners();
    test_gain_corners();
    test_output_backpressure();
    test_random_drive();
    settle_block();
    if (expected_drive.size() != 0) begin
      $error("%0d bridge results never arrived", expected_drive.size());
      err_count++;
    end
    $display("%0d pad requests sent, %0d bridge results checked", pad_count, checked_count);
    $display("%0d gain and full scale settings, with stalls and a long sink hold-off",
             setting_count);
    if (err_count == 0) begin
      $display("omni_chassis_wheel_drive_top_tb: done, clean");
    end else begin
      $display("omni_chassis_wheel_drive_top_tb: done, errors");
    end
    $finish;
  end

endmodule
